// ----- rtl/nlprs_pkg.sv -----
`timescale 1ns / 1ps
package nlprs_pkg;

	localparam int PAGE_BYTES = 2048;
	localparam int COL_BITS   = $clog2(PAGE_BYTES);

	localparam logic [7:0] CMD_READ_SETUP   = 8'h00;
	localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_READY = 2'd1,
		OP_DATA  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_SELECT   = 3'd0,
		ACT_CMD      = 3'd1,
		ACT_ADDR     = 3'd2,
		ACT_STROBE   = 3'd3,
		ACT_DESELECT = 3'd4,
		ACT_STORE    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_READ = 2'd2
	} phase_t;

	// what the back end has to play out for one accepted item
	typedef enum logic [2:0] {
		JOB_START       = 3'd0,
		JOB_START_EMPTY = 3'd1,
		JOB_STROBE      = 3'd2,
		JOB_STORE_END   = 3'd3,
		JOB_STORE_PAGE  = 3'd4,
		JOB_STORE_NEXT  = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] addr;
		logic [31:0] index;
		logic [7:0]  data;
	} job_t;

	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] STEP_LAST_HEADER = 3'd7;

endpackage

// ----- rtl/nlprs_req_if.sv -----
`timescale 1ns / 1ps
interface nlprs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] start_address;
	logic [31:0] byte_count;
	logic        ready_bit;
	logic [7:0]  flash_byte;

	modport source (output valid, opcode, start_address, byte_count, ready_bit, flash_byte,
		input ready);
	modport sink (input valid, opcode, start_address, byte_count, ready_bit, flash_byte,
		output ready);
endinterface

// ----- rtl/nlprs_rsp_if.sv -----
`timescale 1ns / 1ps
interface nlprs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  bus_byte;
	logic [31:0] buffer_index;
	logic [7:0]  buffer_byte;
	logic        last;

	modport source (output valid, action, bus_byte, buffer_index, buffer_byte, last,
		input ready);
	modport sink (input valid, action, bus_byte, buffer_index, buffer_byte, last,
		output ready);
endinterface

// ----- rtl/nlprs_front.sv -----
`timescale 1ns / 1ps
module nlprs_front (
	input  logic             clk,
	input  logic             arst_n,
	nlprs_req_if.sink        req,
	input  logic             q_ready,
	output logic             push,
	output nlprs_pkg::job_t  push_job
);
	import nlprs_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] cur_addr_q, done_q, total_q;
	logic [31:0] nxt_addr, nxt_done;
	logic        take;
	logic        do_start, do_ready, do_data;
	logic        data_end, page_end;
	opcode_t     op;

	assign req.ready = q_ready;
	assign take      = req.valid && q_ready;
	assign op        = opcode_t'(req.opcode);

	assign nxt_addr = cur_addr_q + 32'd1;
	assign nxt_done = done_q + 32'd1;
	assign data_end = (nxt_done == total_q);
	assign page_end = (nxt_addr[COL_BITS-1:0] == '0);

	assign do_start = take && (op == OP_START) && (phase_q == PH_IDLE);
	assign do_ready = take && (op == OP_READY) && (phase_q == PH_WAIT) && req.ready_bit;
	assign do_data  = take && (op == OP_DATA) && (phase_q == PH_READ);

	always_comb begin
		phase_d = phase_q;
		priority if (do_start) begin
			phase_d = (req.byte_count == 32'd0) ? PH_IDLE : PH_WAIT;
		end else if (do_ready) begin
			phase_d = PH_READ;
		end else if (do_data) begin
			if (data_end) begin
				phase_d = PH_IDLE;
			end else if (page_end) begin
				phase_d = PH_WAIT;
			end
		end else begin
			phase_d = phase_q;
		end
	end

	always_comb begin
		push     = do_start || do_ready || do_data;
		push_job = '{kind: JOB_STROBE, addr: nxt_addr, index: done_q, data: req.flash_byte};
		priority if (do_start) begin
			push_job.kind = (req.byte_count == 32'd0) ? JOB_START_EMPTY : JOB_START;
			push_job.addr = req.start_address;
		end else if (do_data) begin
			if (data_end) begin
				push_job.kind = JOB_STORE_END;
			end else if (page_end) begin
				push_job.kind = JOB_STORE_PAGE;
			end else begin
				push_job.kind = JOB_STORE_NEXT;
			end
		end else begin
			push_job.kind = JOB_STROBE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cur_addr_q <= '0;
			done_q     <= '0;
			total_q    <= '0;
		end else begin
			phase_q <= phase_d;
			if (do_start) begin
				cur_addr_q <= req.start_address;
				total_q    <= req.byte_count;
				done_q     <= '0;
			end else if (do_data) begin
				cur_addr_q <= nxt_addr;
				done_q     <= nxt_done;
			end
		end
	end

	// a busy sequencer always has bytes left to fetch
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> done_q != total_q)
		else $error("busy with no bytes outstanding");

endmodule

// ----- rtl/nlprs_queue.sv -----
`timescale 1ns / 1ps
module nlprs_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nlprs_pkg::job_t  push_job,
	output logic             ready,
	output logic             head_valid,
	output nlprs_pkg::job_t  head_job,
	input  logic             pop
);
	import nlprs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign ready      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("job pushed into a full queue");

endmodule

// ----- rtl/nlprs_back.sv -----
`timescale 1ns / 1ps
module nlprs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  nlprs_pkg::job_t  head_job,
	output logic             pop,
	nlprs_rsp_if.source      rsp
);
	import nlprs_pkg::*;

	logic [STEP_BITS-1:0] step_q;
	logic                 out_valid_q;
	action_t              action_q, beat_action;
	logic [7:0]           bus_byte_q, beat_bus;
	logic [31:0]          index_q, beat_index;
	logic [7:0]           data_q, beat_data;
	logic                 last_q, beat_last;
	logic                 load;
	logic [15:0]          col;
	logic [31:0]          row;
	logic                 is_start, has_header, short_tail;

	assign col = 16'(head_job.addr[COL_BITS-1:0]);
	assign row = head_job.addr >> COL_BITS;

	assign is_start   = (head_job.kind == JOB_START) || (head_job.kind == JOB_START_EMPTY);
	assign has_header = (head_job.kind == JOB_START) || (head_job.kind == JOB_STORE_PAGE);
	assign short_tail = (head_job.kind == JOB_START_EMPTY) || (head_job.kind == JOB_STORE_END)
		|| (head_job.kind == JOB_STORE_NEXT);

	// step 0 is the select, strobe or store beat, later steps are the tail of the job
	always_comb begin
		beat_action = ACT_STROBE;
		beat_bus    = 8'h00;
		beat_index  = 32'd0;
		beat_data   = 8'h00;
		beat_last   = 1'b0;
		if (step_q == '0) begin
			if (is_start) begin
				beat_action = ACT_SELECT;
			end else if (head_job.kind == JOB_STROBE) begin
				beat_action = ACT_STROBE;
				beat_last   = 1'b1;
			end else begin
				beat_action = ACT_STORE;
				beat_index  = head_job.index;
				beat_data   = head_job.data;
			end
		end else if (has_header) begin
			beat_action = ACT_ADDR;
			unique case (step_q)
				3'd1: begin
					beat_action = ACT_CMD;
					beat_bus    = CMD_READ_SETUP;
				end
				3'd2: beat_bus = col[7:0];
				3'd3: beat_bus = col[15:8];
				3'd4: beat_bus = row[7:0];
				3'd5: beat_bus = row[15:8];
				3'd6: beat_bus = row[23:16];
				default: begin
					beat_action = ACT_CMD;
					beat_bus    = CMD_READ_CONFIRM;
					beat_last   = 1'b1;
				end
			endcase
		end else begin
			beat_action = (head_job.kind == JOB_STORE_NEXT) ? ACT_STROBE : ACT_DESELECT;
			beat_last   = 1'b1;
		end
	end

	assign load = head_valid && (!out_valid_q || rsp.ready);
	assign pop  = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= beat_last ? '0 : step_q + STEP_BITS'(1);
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action_q   <= beat_action;
			bus_byte_q <= beat_bus;
			index_q    <= beat_index;
			data_q     <= beat_data;
			last_q     <= beat_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.action       = action_q;
	assign rsp.bus_byte     = bus_byte_q;
	assign rsp.buffer_index = index_q;
	assign rsp.buffer_byte  = data_q;
	assign rsp.last         = last_q;

	// a job part-way through stays at the head of the queue
	a_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> head_valid)
		else $error("step counter running with no job");

	// only header jobs run past their second beat
	a_long_job_header: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && step_q > STEP_BITS'(1)) |-> has_header)
		else $error("short job ran past its tail");

	a_tail_short: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && short_tail && step_q == STEP_BITS'(1)) |-> pop || !load)
		else $error("short job not retired on its tail beat");

endmodule

// ----- rtl/nand_large_page_read_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Large-page NAND read sequencer. Items on req are start requests, ready samples and returned
// data bytes; each that fits the current phase (a ready sample only with ready_bit set) gives
// a burst of flash actions on rsp, the final one marked with last. A start gives select plus
// the seven-beat page header (00h, two column bytes, three row bytes, 30h), or select then
// deselect for zero length; a data byte gives a buffer write followed by the next strobe, a
// new page header or the deselect. The front end takes one item per cycle while the queue has
// room and files it as a job in a QUEUE_DEPTH entry queue; the back end plays out one action
// per cycle while rsp is ready, through its output register. An item's first action passes
// through the queue and then the output register before it is presented on rsp.
module nand_large_page_read_sequencer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	nlprs_req_if.sink   req,
	nlprs_rsp_if.source rsp
);
	import nlprs_pkg::*;

	logic q_ready, push, head_valid, pop;
	job_t push_job, head_job;

	nlprs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_ready  (q_ready),
		.push     (push),
		.push_job (push_job)
	);

	nlprs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.ready      (q_ready),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	nlprs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
